@@ rtl/owbm_pkg.sv @@
// ----------------------------------------------------------------------------
// One-wire bus master package
// Phase codes, register indexes, register reset values and the result record
// that the phase-advance helpers hand back to the master unit.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

   // Bus phase codes.
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_RST_LOW  = 3'd1;
   localparam logic [2:0] PH_RST_WAIT = 3'd2;
   localparam logic [2:0] PH_RST_TAIL = 3'd3;
   localparam logic [2:0] PH_WR_LOW   = 3'd4;
   localparam logic [2:0] PH_WR_REC   = 3'd5;
   localparam logic [2:0] PH_RD_LOW   = 3'd6;
   localparam logic [2:0] PH_RD_SLOT  = 3'd7;

   // Command codes.
   localparam logic [1:0] CMD_RESET = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_TICKS_PER_US     = 3'd0;
   localparam logic [2:0] REG_RESET_LOW_US     = 3'd1;
   localparam logic [2:0] REG_PRESENCE_WAIT_US = 3'd2;
   localparam logic [2:0] REG_RESET_TAIL_US    = 3'd3;
   localparam logic [2:0] REG_SLOT_US          = 3'd4;
   localparam logic [2:0] REG_SHORT_LOW_US     = 3'd5;
   localparam logic [2:0] REG_RECOVERY_US      = 3'd6;
   localparam logic [2:0] REG_READ_SAMPLE_US   = 3'd7;

   // Register reset values.
   localparam logic [7:0] RST_TICKS_PER_US     = 8'd64;
   localparam logic [9:0] RST_RESET_LOW_US     = 10'd480;
   localparam logic [9:0] RST_PRESENCE_WAIT_US = 10'd80;
   localparam logic [9:0] RST_RESET_TAIL_US    = 10'd400;
   localparam logic [7:0] RST_SLOT_US          = 8'd60;
   localparam logic [7:0] RST_SHORT_LOW_US     = 8'd1;
   localparam logic [7:0] RST_RECOVERY_US      = 8'd10;
   localparam logic [7:0] RST_READ_SAMPLE_US   = 8'd15;

   // Microsecond counter saturates here.
   localparam logic [9:0] US_MAX = 10'd1023;

   // Outcome of advancing through one or more bus phases.
   typedef struct packed {
      logic [2:0] phase;
      logic [2:0] bit_idx;
      logic [7:0] shift;
      logic       done;
   } step_type;

endpackage

`default_nettype wire

@@ rtl/one_wire_bus_master_unit.sv @@
// ----------------------------------------------------------------------------
// One-wire bus master unit
// Each transfer on the request channel is one tick of bus timing; it carries
// a start strobe, a command, a byte to send and the sampled line level. Each
// tick produces one result: drive-low, busy, done, presence and the last
// received byte.
//
// Usage:
//  - req_* channel: one transfer per bus tick. req_tdata holds start_req,
//    cmd, tx_byte and line_level. A start is taken only while idle.
//  - rsp_* channel: one transfer per request, in order. rsp_tdata holds
//    drive_low, busy_res, done_res, presence and rx_byte.
//  - csr_* port: write-only register file; the user writes it while the bus is idle, not enforced by the block.
//  - A request transfer is held in the input register, then the phase update
//    writes its result into the result register, which drives rsp_tvalid.
//    Throughput is one tick per cycle while the receiver takes results; the
//    phase update for a tick finishes in one pass, zero-length phases included.
//  - Reset returns the registers to their defaults, the bus to idle and
//    empties both registers stages.
//  - When the receiver stalls, the result is held and the input register
//    fills; req_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_unit
   import owbm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // start_req, cmd[1:0], tx_byte[7:0], line_level, pad
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // drive_low, busy_res, done_res, presence,
                                        // rx_byte[7:0], pad
   // Configuration write port.
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_wdata
);

   // -------------------------------------------------------------------------
   // Phase-advance helpers
   // -------------------------------------------------------------------------

   // Enter the low part of a written bit with a fresh timer and pass any
   // zero-length phases that follow.
   function automatic step_type enter_wr(logic [2:0] b, logic [7:0] s,
                                         logic zs, logic zl, logic zr);
      step_type   r;
      logic       found;
      logic [3:0] pos;
      r.phase   = PH_WR_LOW;
      r.bit_idx = b;
      r.shift   = s;
      r.done    = 1'b0;
      found     = 1'b0;
      pos       = 4'd0;
      if (s[0] ? zs : zl) begin
         if (!zr) begin
            r.phase = PH_WR_REC;
         end else begin
            // Both the low time and recovery vanish: find the next bit with
            // a nonzero low time, if any.
            r.phase = PH_IDLE;
            r.done  = 1'b1;
            for (int k = 1; k < 8; k++) begin
               pos = {1'b0, b} + 4'(k);
               if (!found && pos <= 4'd7 && !(s[k] ? zs : zl)) begin
                  found     = 1'b1;
                  r.phase   = PH_WR_LOW;
                  r.bit_idx = pos[2:0];
                  r.shift   = s >> k;
                  r.done    = 1'b0;
               end
            end
         end
      end
      return r;
   endfunction

   // Recovery of a written bit is over: next bit or finish.
   function automatic step_type after_rec(logic [2:0] b, logic [7:0] s,
                                          logic zs, logic zl, logic zr);
      step_type r;
      r.phase   = PH_IDLE;
      r.bit_idx = b;
      r.shift   = s;
      r.done    = 1'b1;
      if (b != 3'd7) begin
         r = enter_wr(b + 3'd1, s >> 1, zs, zl, zr);
      end
      return r;
   endfunction

   // Enter a read slot with a fresh timer.
   function automatic step_type enter_rd(logic [2:0] b, logic [7:0] s,
                                         logic zs, logic zl);
      step_type r;
      r.phase   = PH_RD_LOW;
      r.bit_idx = b;
      r.shift   = s;
      r.done    = 1'b0;
      if (zs) begin
         if (!zl) begin
            r.phase = PH_RD_SLOT;
         end else begin
            // Every remaining slot ends at once and reads a zero.
            r.phase = PH_IDLE;
            r.done  = 1'b1;
            r.shift = s >> (4'd8 - {1'b0, b});
         end
      end
      return r;
   endfunction

   // End a read slot: shift in the sampled bit, then next slot or finish.
   function automatic step_type end_rd(logic [2:0] b, logic [7:0] s, logic saw,
                                       logic zs, logic zl);
      step_type   r;
      logic [7:0] s2;
      s2        = {saw, s[7:1]};
      r.phase   = PH_IDLE;
      r.bit_idx = b;
      r.shift   = s2;
      r.done    = 1'b1;
      if (b != 3'd7) begin
         r = enter_rd(b + 3'd1, s2, zs, zl);
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Declarations
   // -------------------------------------------------------------------------
   logic [7:0] ticks_per_us_ff;
   logic [9:0] reset_low_us_ff;
   logic [9:0] presence_wait_us_ff;
   logic [9:0] reset_tail_us_ff;
   logic [7:0] slot_us_ff;
   logic [7:0] short_low_us_ff;
   logic [7:0] recovery_us_ff;
   logic [7:0] read_sample_us_ff;

   logic [2:0] phase_ff,         phase_in;
   logic [7:0] tick_prescale_ff, tick_prescale_in;
   logic [9:0] us_count_ff,      us_count_in;
   logic [2:0] bit_index_ff,     bit_index_in;
   logic [7:0] shift_byte_ff,    shift_byte_in;
   logic       saw_high_ff,      saw_high_in;
   logic       presence_flag_ff, presence_flag_in;
   logic [7:0] received_byte_ff, received_byte_in;
   logic       done_in;

   logic       in_valid_ff;
   logic       in_start_ff;
   logic [1:0] in_cmd_ff;
   logic [7:0] in_tx_ff;
   logic       in_line_ff;

   logic        out_valid_ff;
   logic [15:0] out_data_ff, out_data_in;

   logic       advance;
   logic [7:0] tp;
   logic [8:0] ps_inc;
   logic       ps_wrap;
   logic [7:0] ps_new;
   logic [9:0] us_new;
   logic       z_slot, z_short, z_rec, z_rlow, z_pwait, z_tail;
   logic       restart, go_wait, go_tail, go_end;
   logic [7:0] wr_len;
   step_type   step;
   logic       drive_in;

   // -------------------------------------------------------------------------
   // Handshake: input register feeds the result register.
   // -------------------------------------------------------------------------
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Request and result payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_start_ff <= req_tdata[0];
         in_cmd_ff   <= req_tdata[2:1];
         in_tx_ff    <= req_tdata[10:3];
         in_line_ff  <= req_tdata[11];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // -------------------------------------------------------------------------
   // Configuration registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_us_ff     <= RST_TICKS_PER_US;
         reset_low_us_ff     <= RST_RESET_LOW_US;
         presence_wait_us_ff <= RST_PRESENCE_WAIT_US;
         reset_tail_us_ff    <= RST_RESET_TAIL_US;
         slot_us_ff          <= RST_SLOT_US;
         short_low_us_ff     <= RST_SHORT_LOW_US;
         recovery_us_ff      <= RST_RECOVERY_US;
         read_sample_us_ff   <= RST_READ_SAMPLE_US;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_TICKS_PER_US:     ticks_per_us_ff     <= csr_wdata[7:0];
            REG_RESET_LOW_US:     reset_low_us_ff     <= csr_wdata;
            REG_PRESENCE_WAIT_US: presence_wait_us_ff <= csr_wdata;
            REG_RESET_TAIL_US:    reset_tail_us_ff    <= csr_wdata;
            REG_SLOT_US:          slot_us_ff          <= csr_wdata[7:0];
            REG_SHORT_LOW_US:     short_low_us_ff     <= csr_wdata[7:0];
            REG_RECOVERY_US:      recovery_us_ff      <= csr_wdata[7:0];
            REG_READ_SAMPLE_US:   read_sample_us_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Timer step: prescaler to microseconds, saturating count.
   // -------------------------------------------------------------------------
   assign tp      = (ticks_per_us_ff == 8'd0) ? 8'd1 : ticks_per_us_ff;
   assign ps_inc  = {1'b0, tick_prescale_ff} + 9'd1;
   assign ps_wrap = ps_inc >= {1'b0, tp};
   assign ps_new  = ps_wrap ? 8'd0 : ps_inc[7:0];
   assign us_new  = (ps_wrap && us_count_ff != US_MAX) ? us_count_ff + 10'd1 : us_count_ff;

   assign z_slot  = slot_us_ff == 8'd0;
   assign z_short = short_low_us_ff == 8'd0;
   assign z_rec   = recovery_us_ff == 8'd0;
   assign z_rlow  = reset_low_us_ff == 10'd0;
   assign z_pwait = presence_wait_us_ff == 10'd0;
   assign z_tail  = reset_tail_us_ff == 10'd0;
   assign wr_len  = shift_byte_ff[0] ? short_low_us_ff : slot_us_ff;

   // -------------------------------------------------------------------------
   // Phase update for one tick, zero-length phases passed in the same tick.
   // -------------------------------------------------------------------------
   always_comb begin
      phase_in         = phase_ff;
      bit_index_in     = bit_index_ff;
      shift_byte_in    = shift_byte_ff;
      saw_high_in      = saw_high_ff;
      presence_flag_in = presence_flag_ff;
      received_byte_in = received_byte_ff;
      tick_prescale_in = tick_prescale_ff;
      us_count_in      = us_count_ff;
      done_in          = 1'b0;
      restart          = 1'b0;
      go_wait          = 1'b0;
      go_tail          = 1'b0;
      go_end           = 1'b0;
      step             = '0;

      if (phase_ff == PH_IDLE) begin
         // Launch a command; an unknown code is ignored.
         if (in_start_ff && in_cmd_ff != 2'd3) begin
            restart      = 1'b1;
            bit_index_in = 3'd0;
            saw_high_in  = 1'b0;
            case (in_cmd_ff)
               CMD_RESET: begin
                  phase_in = PH_RST_LOW;
                  go_wait  = z_rlow;
               end
               CMD_WRITE: begin
                  step          = enter_wr(3'd0, in_tx_ff, z_short, z_slot, z_rec);
                  phase_in      = step.phase;
                  bit_index_in  = step.bit_idx;
                  shift_byte_in = step.shift;
                  done_in       = step.done;
               end
               default: begin
                  step          = enter_rd(3'd0, 8'd0, z_short, z_slot);
                  phase_in      = step.phase;
                  bit_index_in  = step.bit_idx;
                  shift_byte_in = step.shift;
                  done_in       = step.done;
                  if (step.done) begin
                     received_byte_in = step.shift;
                  end
               end
            endcase
         end
      end else begin
         tick_prescale_in = ps_new;
         us_count_in      = us_new;
         unique case (phase_ff)
            PH_RST_LOW: begin
               go_wait = us_new >= reset_low_us_ff;
            end
            PH_RST_WAIT: begin
               go_tail = us_new >= presence_wait_us_ff;
            end
            PH_RST_TAIL: begin
               go_end = us_new >= reset_tail_us_ff;
            end
            PH_WR_LOW: begin
               if (us_new >= {2'b0, wr_len}) begin
                  restart = 1'b1;
                  if (!z_rec) begin
                     phase_in = PH_WR_REC;
                  end else begin
                     step = after_rec(bit_index_ff, shift_byte_ff, z_short, z_slot, z_rec);
                     phase_in      = step.phase;
                     bit_index_in  = step.bit_idx;
                     shift_byte_in = step.shift;
                     done_in       = step.done;
                  end
               end
            end
            PH_WR_REC: begin
               if (us_new >= {2'b0, recovery_us_ff}) begin
                  restart       = 1'b1;
                  step = after_rec(bit_index_ff, shift_byte_ff, z_short, z_slot, z_rec);
                  phase_in      = step.phase;
                  bit_index_in  = step.bit_idx;
                  shift_byte_in = step.shift;
                  done_in       = step.done;
               end
            end
            default: begin
               // Read slot: the low part hands over without restarting the
               // timer, so the slot end is checked against the same count.
               if (phase_ff == PH_RD_LOW && us_new >= {2'b0, short_low_us_ff}) begin
                  phase_in = PH_RD_SLOT;
               end
               if (phase_in == PH_RD_SLOT && us_new >= {2'b0, slot_us_ff}) begin
                  restart       = 1'b1;
                  step = end_rd(bit_index_ff, shift_byte_ff, saw_high_ff, z_short, z_slot);
                  phase_in      = step.phase;
                  bit_index_in  = step.bit_idx;
                  shift_byte_in = step.shift;
                  done_in       = step.done;
                  saw_high_in   = 1'b0;
                  if (step.done) begin
                     received_byte_in = step.shift;
                  end
               end
            end
         endcase
      end

      // Reset-and-presence sequence, with zero-length phases chained.
      if (go_wait) begin
         phase_in = PH_RST_WAIT;
         restart  = 1'b1;
         go_tail  = z_pwait;
      end
      if (go_tail) begin
         presence_flag_in = !in_line_ff;
         phase_in         = PH_RST_TAIL;
         restart          = 1'b1;
         go_end           = z_tail;
      end
      if (go_end) begin
         phase_in = PH_IDLE;
         restart  = 1'b1;
         done_in  = 1'b1;
      end

      if (restart) begin
         tick_prescale_in = 8'd0;
         us_count_in      = 10'd0;
      end

      // Read sampling in the released part of a slot, before the deadline.
      if (phase_in == PH_RD_SLOT && in_line_ff &&
          us_count_in < {2'b0, read_sample_us_ff}) begin
         saw_high_in = 1'b1;
      end
   end

   // Result fields for this tick.
   assign drive_in = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW) ||
                     (phase_in == PH_RD_LOW);
   assign out_data_in = {4'd0, received_byte_in, presence_flag_in, done_in,
                         (phase_in != PH_IDLE), drive_in};

   // -------------------------------------------------------------------------
   // Bus state registers, updated once per tick.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         tick_prescale_ff <= 8'd0;
         us_count_ff      <= 10'd0;
         bit_index_ff     <= 3'd0;
         shift_byte_ff    <= 8'd0;
         saw_high_ff      <= 1'b0;
         presence_flag_ff <= 1'b0;
         received_byte_ff <= 8'd0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         tick_prescale_ff <= tick_prescale_in;
         us_count_ff      <= us_count_in;
         bit_index_ff     <= bit_index_in;
         shift_byte_ff    <= shift_byte_in;
         saw_high_ff      <= saw_high_in;
         presence_flag_ff <= presence_flag_in;
         received_byte_ff <= received_byte_in;
      end
   end

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------

   // The timer is always cleared when the bus returns to idle.
   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (tick_prescale_ff == 8'd0 && us_count_ff == 10'd0))
      else $error("timer not cleared in idle");

   // A processed tick always leaves a result waiting.
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed tick produced no result");

   // A finishing tick leaves the bus idle.
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      advance && done_in |=> phase_ff == PH_IDLE)
      else $error("command finished but bus not idle");

   // A held result never shows done while busy, nor drive while idle.
   a_result_consistent: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!(out_data_ff[2] && out_data_ff[1]) &&
                        !(out_data_ff[0] && !out_data_ff[1])))
      else $error("inconsistent result flags");

endmodule

`default_nettype wire
